/* design/midi_track_event_encoder_top_defines.svh */
// -----------------------------------------------------------------------------
// MIDI track event encoder assertion macros
// Shared assertion shorthands for the encoder's checks.
// -----------------------------------------------------------------------------
`ifndef MIDI_TRACK_EVENT_ENCODER_TOP_DEFINES_SVH
`define MIDI_TRACK_EVENT_ENCODER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MET_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MET_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/met_pkg.sv */
// -----------------------------------------------------------------------------
// MIDI track event encoder package
// Beat types, event codes, byte constants and the queue record.
// -----------------------------------------------------------------------------
package met_pkg;

	// Event codes carried in the mode field.
	localparam logic [2:0] MODE_NOTE_OFF = 3'd0;
	localparam logic [2:0] MODE_NOTE_ON  = 3'd1;
	localparam logic [2:0] MODE_PROGRAM  = 3'd2;
	localparam logic [2:0] MODE_TEMPO    = 3'd3;
	localparam logic [2:0] MODE_END      = 3'd4;

	// Status nibbles and meta event bytes.
	localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
	localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
	localparam logic [3:0] STATUS_PROGRAM  = 4'hC;
	localparam logic [7:0] BYTE_ZERO       = 8'h00;
	localparam logic [7:0] META_PREFIX     = 8'hFF;
	localparam logic [7:0] META_TEMPO      = 8'h51;
	localparam logic [7:0] META_TEMPO_LEN  = 8'h03;
	localparam logic [7:0] META_END        = 8'h2F;

	// Delta and tempo limits.
	localparam int DELTA_W = 28;
	localparam int TEMPO_W = 24;
	localparam logic [DELTA_W-1:0] DELTA_MAX = 28'hFFF_FFFF;
	localparam logic [TEMPO_W-1:0] TEMPO_MAX = 24'hFFFFFF;

	// Tempo divider: microseconds per minute over beats per minute.
	localparam int DIVIDEND_W = 26;
	localparam int DIVISOR_W  = 16;
	localparam logic [DIVIDEND_W-1:0] US_PER_MINUTE = 26'd60000000;
	localparam int DIV_CNT_W = 5;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = 5'(DIVIDEND_W - 1);

	// Queue between the front and back parts.
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = 1;
	localparam int QUEUE_CNT_W = 2;

	// Configuration port.
	localparam int PADDR_W = 2;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-1:0] ADDR_CHANNEL = 2'd0;

	// Input beat.
	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] tick;
		logic [6:0]  pitch;
		logic [6:0]  velocity;
		logic [6:0]  instrument;
		logic [15:0] bpm;
	} in_item_t;

	// Output beat.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} out_item_t;

	// Classified event waiting for the back part.
	typedef struct packed {
		logic [2:0]         mode;
		logic [DELTA_W-1:0] delta;
		logic [6:0]         pitch;
		logic [6:0]         data7;
		logic [15:0]        bpm;
		logic [3:0]         channel;
	} cmd_t;

	// Queue occupancy flags.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	// Divider request and response.
	typedef struct packed {
		logic                 start;
		logic [DIVISOR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
	} div_rsp_t;

endpackage

/* design/met_front.sv */
// -----------------------------------------------------------------------------
// MIDI track event encoder front part
// Accepts events, works out the note delta and queues events that emit bytes.
// -----------------------------------------------------------------------------
module met_front
	import met_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_item,
	input  logic [3:0]  channel,
	input  queue_stat_t q_stat,
	output logic        push,
	output cmd_t        push_cmd
);

	logic [31:0]        last_tick_q;
	logic               accept;
	logic               is_note;
	logic               emits;
	logic [31:0]        diff;
	logic [DELTA_W-1:0] delta;

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign is_note  = (in_item.mode == MODE_NOTE_OFF) || (in_item.mode == MODE_NOTE_ON);

	// Delta from the last note, clamped at zero and saturated to 28 bits.
	always_comb begin
		diff = in_item.tick - last_tick_q;
		if (in_item.tick < last_tick_q) begin
			delta = '0;
		end else if (diff > {4'd0, DELTA_MAX}) begin
			delta = DELTA_MAX;
		end else begin
			delta = diff[DELTA_W-1:0];
		end
	end

	// Decide whether the event produces any bytes at all.
	always_comb begin
		unique case (in_item.mode)
			MODE_NOTE_OFF, MODE_NOTE_ON: emits = 1'b1;
			MODE_PROGRAM:                emits = (in_item.instrument != 7'd0);
			MODE_TEMPO:                  emits = (in_item.bpm != 16'd0);
			MODE_END:                    emits = 1'b1;
			default:                     emits = 1'b0;
		endcase
	end

	// Build the queue record.
	always_comb begin
		push_cmd.mode    = in_item.mode;
		push_cmd.delta   = delta;
		push_cmd.pitch   = in_item.pitch;
		push_cmd.bpm     = in_item.bpm;
		push_cmd.channel = channel;
		if (in_item.mode == MODE_NOTE_ON) begin
			push_cmd.data7 = in_item.velocity;
		end else if (in_item.mode == MODE_PROGRAM) begin
			push_cmd.data7 = in_item.instrument;
		end else begin
			push_cmd.data7 = 7'd0;
		end
	end

	assign push = accept && emits;

	// Only note events move the reference tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_tick_q <= '0;
		end else if (accept && is_note) begin
			last_tick_q <= in_item.tick;
		end
	end

endmodule

/* design/met_queue.sv */
// -----------------------------------------------------------------------------
// MIDI track event encoder queue
// Short register queue between the front and back parts.
// -----------------------------------------------------------------------------
module met_queue
	import met_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  cmd_t        push_cmd,
	input  logic        pop,
	output cmd_t        pop_cmd,
	output queue_stat_t stat
);

	cmd_t                   entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wptr_q;
	logic [QUEUE_PTR_W-1:0] rptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	assign stat.full  = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_cmd    = entry_q[rptr_q];

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_cmd;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/met_divider.sv */
// -----------------------------------------------------------------------------
// MIDI track event encoder tempo divider
// Restoring divider, one quotient bit per cycle, for the tempo value.
// -----------------------------------------------------------------------------
module met_divider
	import met_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [DIVISOR_W-1:0]  divisor_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W:0]    shifted;
	logic [DIVISOR_W:0]    diff;
	logic                  ge;

	// One restoring step.
	always_comb begin
		shifted = {rem_q, quo_q[DIVIDEND_W-1]};
		diff    = shifted - {1'b0, divisor_q};
		ge      = (shifted >= {1'b0, divisor_q});
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			divisor_q <= req.divisor;
			rem_q     <= '0;
			quo_q     <= US_PER_MINUTE;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
		end
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

/* design/met_back.sv */
// -----------------------------------------------------------------------------
// MIDI track event encoder back part
// Takes queued events and sends their bytes one beat per cycle while out_ready holds.
// -----------------------------------------------------------------------------
module met_back
	import met_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  queue_stat_t q_stat,
	input  cmd_t        q_cmd,
	output logic        pop,
	output div_req_t    div_req,
	input  div_rsp_t    div_rsp,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_item
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]         state_q;
	cmd_t               cmd_q;
	logic [2:0]         groups_q;
	logic [2:0]         last_idx_q;
	logic [2:0]         idx_q;
	logic [TEMPO_W-1:0] tempo_q;
	logic               out_valid_q;
	out_item_t          out_item_q;
	logic [2:0]         groups_in;
	logic [2:0]         last_idx_in;
	logic               slot_free;
	logic               emit;
	logic [7:0]         byte_sel;
	logic [2:0]         k_full;
	logic [1:0]         k;
	logic [2:0]         j;
	logic [6:0]         part;

	// Number of delta bytes for the event at the head of the queue.
	always_comb begin
		if (q_cmd.delta[DELTA_W-1:7] == '0) begin
			groups_in = 3'd1;
		end else if (q_cmd.delta[DELTA_W-1:14] == '0) begin
			groups_in = 3'd2;
		end else if (q_cmd.delta[DELTA_W-1:21] == '0) begin
			groups_in = 3'd3;
		end else begin
			groups_in = 3'd4;
		end
	end

	// Index of the final byte of that event.
	always_comb begin
		unique case (q_cmd.mode)
			MODE_NOTE_OFF, MODE_NOTE_ON: last_idx_in = groups_in + 3'd2;
			MODE_PROGRAM:                last_idx_in = 3'd2;
			MODE_TEMPO:                  last_idx_in = 3'd6;
			default:                     last_idx_in = 3'd3;
		endcase
	end

	// Byte for the current position within the event.
	always_comb begin
		k_full = groups_q - idx_q - 3'd1;
		k      = k_full[1:0];
		j      = idx_q - groups_q;
		unique case (k)
			2'd0:    part = cmd_q.delta[6:0];
			2'd1:    part = cmd_q.delta[13:7];
			2'd2:    part = cmd_q.delta[20:14];
			default: part = cmd_q.delta[27:21];
		endcase
		byte_sel = BYTE_ZERO;
		unique case (cmd_q.mode)
			MODE_NOTE_OFF, MODE_NOTE_ON: begin
				if (idx_q < groups_q) begin
					byte_sel = {(k != 2'd0), part};
				end else if (j == 3'd0) begin
					byte_sel = {(cmd_q.mode == MODE_NOTE_ON) ? STATUS_NOTE_ON : STATUS_NOTE_OFF,
						cmd_q.channel};
				end else if (j == 3'd1) begin
					byte_sel = {1'b0, cmd_q.pitch};
				end else begin
					byte_sel = {1'b0, cmd_q.data7};
				end
			end
			MODE_PROGRAM: begin
				unique case (idx_q)
					3'd1:    byte_sel = {STATUS_PROGRAM, cmd_q.channel};
					3'd2:    byte_sel = {1'b0, cmd_q.data7};
					default: byte_sel = BYTE_ZERO;
				endcase
			end
			MODE_TEMPO: begin
				unique case (idx_q)
					3'd1:    byte_sel = META_PREFIX;
					3'd2:    byte_sel = META_TEMPO;
					3'd3:    byte_sel = META_TEMPO_LEN;
					3'd4:    byte_sel = tempo_q[23:16];
					3'd5:    byte_sel = tempo_q[15:8];
					3'd6:    byte_sel = tempo_q[7:0];
					default: byte_sel = BYTE_ZERO;
				endcase
			end
			default: begin
				unique case (idx_q)
					3'd1:    byte_sel = META_PREFIX;
					3'd2:    byte_sel = META_END;
					default: byte_sel = BYTE_ZERO;
				endcase
			end
		endcase
	end

	assign slot_free       = !out_valid_q || out_ready;
	assign emit            = (state_q == ST_EMIT) && slot_free;
	assign pop             = (state_q == ST_IDLE) && !q_stat.empty;
	assign div_req.start   = pop && (q_cmd.mode == MODE_TEMPO);
	assign div_req.divisor = q_cmd.bpm;

	// Event registers, loaded on pop; also the tempo value and the output byte.
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q      <= q_cmd;
			groups_q   <= groups_in;
			last_idx_q <= last_idx_in;
		end
		if ((state_q == ST_DIV) && div_rsp.done) begin
			if (div_rsp.quotient[DIVIDEND_W-1:TEMPO_W] != '0) begin
				tempo_q <= TEMPO_MAX;
			end else begin
				tempo_q <= div_rsp.quotient[TEMPO_W-1:0];
			end
		end
		if (emit) begin
			out_item_q.data_byte <= byte_sel;
			out_item_q.last_byte <= (idx_q == last_idx_q);
		end
	end

	// Sequencer and output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (pop) begin
						state_q <= (q_cmd.mode == MODE_TEMPO) ? ST_DIV : ST_EMIT;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == last_idx_q) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

/* design/midi_track_event_encoder_top.sv */
// -----------------------------------------------------------------------------
// MIDI track event encoder top level
// Turns track events into Standard MIDI File track bytes.
// -----------------------------------------------------------------------------
// Events arrive on the in channel (in_valid, in_ready, in_item) and bytes leave
// on the out channel (out_valid, out_ready, out_item), one byte per beat, with
// last_byte set on the final byte of each event. The channel register is
// written through the APB port at address 0; the user must write it only while
// the block is idle, as the block itself does not enforce this. A front part
// classifies each event and computes the note delta in the cycle it is
// accepted; a two-entry queue hands it to the back part, which sends the bytes
// from an output register. An event passes through the queue entry, the back
// part's event registers and the output register. The back part takes an
// event and then sends its bytes; a tempo event first waits for the 26-step
// restoring divider that forms the microseconds per beat. Events that produce
// no bytes are accepted and dropped.
// Reset clears the queue, the sequencer, the last note tick and the channel.
// When the receiver stalls, the current byte is held in the output register;
// the queue keeps taking events until it is full, then in_ready drops.
module midi_track_event_encoder_top
	import met_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_item_t           in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output out_item_t          out_item,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

`include "midi_track_event_encoder_top_defines.svh"

	logic [3:0]  channel_q;
	logic        push;
	cmd_t        push_cmd;
	logic        pop;
	cmd_t        pop_cmd;
	queue_stat_t q_stat;
	div_req_t    div_req;
	div_rsp_t    div_rsp;

	// Configuration register.
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_CHANNEL) ? {28'd0, channel_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q <= '0;
		end else if (psel && penable && pwrite && pready && (paddr == ADDR_CHANNEL)) begin
			channel_q <= pwdata[3:0];
		end
	end

	// Front part, queue, divider and back part.
	met_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.channel  (channel_q),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	met_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.stat     (q_stat)
	);

	met_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	met_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.q_cmd     (pop_cmd),
		.pop       (pop),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// Checks on the queue and divider hand-offs.
	`MET_ASSERT_SAME(a_push_not_full, clk, arst_n, push, !q_stat.full, "push into full queue")
	`MET_ASSERT_SAME(a_pop_not_empty, clk, arst_n, pop, !q_stat.empty, "pop from empty queue")
	`MET_ASSERT_NEXT(a_div_not_instant, clk, arst_n, div_req.start, !div_rsp.done, "divider done too early")

endmodule
